FILE: rtl/mca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI chord arpeggiator package
// Shared widths, register indexes, control/status bundles and the chord
// interval table.
// ----------------------------------------------------------------------------
package mca_pkg;

   // Payload widths
   localparam int ROOT_W   = 7;
   localparam int START_W  = 16;
   localparam int NOTE_W   = 8;
   localparam int POS_W    = 24;
   localparam int OFFS_W   = 5;
   localparam int SEQ_W    = 4;

   // Step divider widths: 60*sample_rate over tempo shifted by the division
   localparam int RATE_W     = 18;
   localparam int TEMPO_W    = 9;
   localparam int DIVIDEND_W = 24;
   localparam int DIVISOR_W  = 12;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_CHORD_SHAPE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARP_ORDER     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOTE_DIVISION = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_COUNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO_BPM     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE   = 3'd5;

   // Arpeggio orders
   localparam logic [1:0] ORDER_UP       = 2'd0;
   localparam logic [1:0] ORDER_DOWN     = 2'd1;
   localparam logic [1:0] ORDER_PINGPONG = 2'd2;
   localparam logic [1:0] ORDER_SHUFFLE  = 2'd3;   // not built, plays as up

   // Controller to datapath
   typedef struct packed {
      logic load;      // latch root and start, launch the step divider
      logic emit_on;   // present the note-on of the current chord note
      logic emit_off;  // present the note-off, then advance
   } mca_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic chord_empty;
      logic div_done;
      logic last_note;
   } mca_sts_type;

   // Semitone offset of chord note idx above the root (triad over octaves)
   function automatic logic [OFFS_W-1:0] chord_offset(input logic minor,
                                                      input logic [SEQ_W-1:0] idx);
      logic [OFFS_W-1:0] mid;
      mid = minor ? 5'd3 : 5'd4;
      case (idx)
         4'd0:    chord_offset = 5'd0;
         4'd1:    chord_offset = mid;
         4'd2:    chord_offset = 5'd7;
         4'd3:    chord_offset = 5'd12;
         4'd4:    chord_offset = 5'd12 + mid;
         4'd5:    chord_offset = 5'd19;
         4'd6:    chord_offset = 5'd24;
         4'd7:    chord_offset = 5'd24 + mid;
         4'd8:    chord_offset = 5'd31;
         default: chord_offset = 5'd0;
      endcase
   endfunction

endpackage
`default_nettype wire

FILE: rtl/mca_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Step divider
// Restoring unsigned divider, one quotient bit per cycle. The quotient holds
// after the done pulse until the next start.
// ----------------------------------------------------------------------------
module mca_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [mca_pkg::DIVIDEND_W-1:0]   dividend,
   input  wire logic [mca_pkg::DIVISOR_W-1:0]    divisor,
   output logic                                  done,
   output logic [mca_pkg::DIVIDEND_W-1:0]        quotient
);
   import mca_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DIVIDEND_W - 1);

   logic                  run_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] q_ff;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  qbit;

   assign trial  = {rem_ff, q_ff[DIVIDEND_W-1]};
   assign qbit   = (trial >= {1'b0, divisor});
   assign diff   = trial - {1'b0, divisor};
   assign rem_in = qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && (cnt_ff == LAST_CNT);
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_CNT) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         q_ff   <= dividend;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         q_ff   <= {q_ff[DIVIDEND_W-2:0], qbit};
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule
`default_nettype wire

FILE: rtl/mca_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Arpeggiator datapath
// Configuration registers, step divider, sequence index and position
// accumulator, and the result fields.
// ----------------------------------------------------------------------------
module mca_dp (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [mca_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mca_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [mca_pkg::ROOT_W-1:0]       root_note,
   input  wire logic [mca_pkg::START_W-1:0]      start_position,
   input  wire mca_pkg::mca_cmd_type             cmd,
   output mca_pkg::mca_sts_type                  sts,
   output logic [mca_pkg::NOTE_W-1:0]            event_note,
   output logic                                  event_is_on,
   output logic [mca_pkg::POS_W-1:0]             event_position,
   output logic                                  last_event
);
   import mca_pkg::*;

   // Configuration
   logic                 shape_ff;
   logic [1:0]           order_ff;
   logic [1:0]           division_ff;
   logic [1:0]           octaves_ff;
   logic [TEMPO_W-1:0]   tempo_ff;
   logic [RATE_W-1:0]    rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff    <= 1'b0;
         order_ff    <= ORDER_UP;
         division_ff <= 2'd0;
         octaves_ff  <= 2'd1;
         tempo_ff    <= TEMPO_W'(120);
         rate_ff     <= RATE_W'(44100);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CHORD_SHAPE:   shape_ff    <= csr_wdata[0];
            CSR_ARP_ORDER:     order_ff    <= csr_wdata[1:0];
            CSR_NOTE_DIVISION: division_ff <= csr_wdata[1:0];
            CSR_OCTAVE_COUNT:  octaves_ff  <= csr_wdata[1:0];
            CSR_TEMPO_BPM:     tempo_ff    <= csr_wdata[TEMPO_W-1:0];
            CSR_SAMPLE_RATE:   rate_ff     <= csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // Step length: 60*rate / (tempo << division), zero tempo taken as one
   logic [DIVIDEND_W-1:0] dividend;
   logic [DIVISOR_W-1:0]  divisor;
   logic [TEMPO_W-1:0]    tempo_eff;
   logic [POS_W-1:0]      step;
   logic                  div_done;

   assign dividend  = {rate_ff, 6'b0} - {4'b0, rate_ff, 2'b0};
   assign tempo_eff = (tempo_ff == '0) ? TEMPO_W'(1) : tempo_ff;
   assign divisor   = {3'b0, tempo_eff} << division_ff;

   mca_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.load),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (step)
   );

   // Sequence bookkeeping
   logic [SEQ_W-1:0]   chord_len;
   logic [SEQ_W:0]     pp_len;
   logic [SEQ_W-1:0]   last_idx;
   logic [SEQ_W-1:0]   chord_idx;
   logic [SEQ_W:0]     pp_down;
   logic [ROOT_W-1:0]  root_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [SEQ_W-1:0]   idx_ff;
   logic [POS_W-1:0]   pos_next;
   logic               last_note;

   assign chord_len = {2'b0, octaves_ff} + {1'b0, octaves_ff, 1'b0};
   assign pp_len    = {chord_len, 1'b0} - 5'd3;
   assign last_idx  = (order_ff == ORDER_PINGPONG) ? pp_len[SEQ_W-1:0]
                                                   : chord_len - 1'b1;
   assign pp_down   = {chord_len, 1'b0} - 5'd2 - {1'b0, idx_ff};

   always_comb begin
      case (order_ff)
         ORDER_DOWN:     chord_idx = chord_len - 1'b1 - idx_ff;
         ORDER_PINGPONG: chord_idx = (idx_ff < chord_len) ? idx_ff
                                                          : pp_down[SEQ_W-1:0];
         default:        chord_idx = idx_ff;
      endcase
   end

   assign pos_next = pos_ff + step;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         root_ff <= root_note;
         pos_ff  <= {{(POS_W-START_W){1'b0}}, start_position};
         idx_ff  <= '0;
      end else if (cmd.emit_off) begin
         pos_ff <= pos_next;
         idx_ff <= idx_ff + 1'b1;
      end
   end

   assign last_note = (idx_ff == last_idx);

   assign sts = '{chord_empty: (octaves_ff == 2'd0),
                  div_done:    div_done,
                  last_note:   last_note};

   assign event_note     = {1'b0, root_ff}
                           + {{(NOTE_W-OFFS_W){1'b0}}, chord_offset(shape_ff, chord_idx)};
   assign event_is_on    = cmd.emit_on;
   assign event_position = cmd.emit_off ? pos_next : pos_ff;
   assign last_event     = cmd.emit_off && last_note;

endmodule
`default_nettype wire

FILE: rtl/mca_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Arpeggiator controller
// Accepts commands, waits out the step division, then walks the chord
// sequence one note-on and one note-off per note.
// ----------------------------------------------------------------------------
module mca_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  is_note_on,
   input  wire mca_pkg::mca_sts_type  sts,
   output logic                       busy,
   output logic                       rsp_valid,
   output mca_pkg::mca_cmd_type       cmd
);
   import mca_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_ON   = 2'd2;
   localparam logic [1:0] ST_OFF  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.emit_on  = 1'b0;
      cmd.emit_off = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // Drop events that are not note-ons or that build no chord
            if (accept && is_note_on && !sts.chord_empty) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_ON;
            end
         end
         ST_ON: begin
            cmd.emit_on = 1'b1;
            state_in    = ST_OFF;
         end
         ST_OFF: begin
            cmd.emit_off = 1'b1;
            state_in     = sts.last_note ? ST_IDLE : ST_ON;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rsp_valid = cmd.emit_on || cmd.emit_off;

endmodule
`default_nettype wire

FILE: rtl/midi_chord_arpeggiator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI chord arpeggiator
// A note-on command builds a major or minor triad over 1 to 3 octaves, orders
// it up, down or ping-pong, and schedules a note-on and a note-off per chord
// note, one step apart.
// ----------------------------------------------------------------------------
// The first result waits for the step divider (restoring, one quotient bit per
//   cycle over a 24-bit dividend) to finish.
// Throughput: after that, 6 to 32 results in consecutive cycles, and a note-on
//   keeps busy high until its last result. Other events and an empty chord
//   produce no result and leave busy low.
// Results carry no back-pressure: each one is valid for exactly one cycle.
// Reset is synchronous: control returns to idle and the configuration takes
//   its reset values (major, up, quarter notes, 1 octave, 120 bpm, 44100 Hz).
// ----------------------------------------------------------------------------
module midi_chord_arpeggiator_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Command channel
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic                             req_is_note_on,
   input  wire logic [mca_pkg::ROOT_W-1:0]       req_root_note,
   input  wire logic [mca_pkg::START_W-1:0]      req_start_position,
   // Result channel
   output logic                                  rsp_valid,
   output logic [mca_pkg::NOTE_W-1:0]            rsp_event_note,
   output logic                                  rsp_event_is_on,
   output logic [mca_pkg::POS_W-1:0]             rsp_event_position,
   output logic                                  rsp_last_event,
   // Configuration write port
   input  wire logic                             csr_we,
   input  wire logic [mca_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mca_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mca_pkg::*;

   mca_cmd_type cmd;
   mca_sts_type sts;

   // Controller: sequences one command at a time
   mca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .is_note_on (req_is_note_on),
      .sts        (sts),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd)
   );

   // Datapath: configuration, step division, chord walk and result fields.
   // Root and start position are latched when a note-on with a chord is taken.
   mca_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .root_note      (req_root_note),
      .start_position (req_start_position),
      .cmd            (cmd),
      .sts            (sts),
      .event_note     (rsp_event_note),
      .event_is_on    (rsp_event_is_on),
      .event_position (rsp_event_position),
      .last_event     (rsp_last_event)
   );

   // A result transfer only happens while a command is in progress
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // Each note-on is followed at once by the note-off of the same note
   a_on_then_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_is_on) |=>
         (rsp_valid && !rsp_event_is_on && rsp_event_note == $past(rsp_event_note)))
      else $error("note-on not followed by its note-off");

   // The next note starts where the previous note-off landed
   a_off_then_on: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_event_is_on && !rsp_last_event) |=>
         (rsp_valid && rsp_event_is_on
          && rsp_event_position == $past(rsp_event_position)))
      else $error("sequence gap after note-off");

   // The final result frees the block for the next command
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_event) |=> !busy)
      else $error("still busy after last result");

endmodule
`default_nettype wire
